// ----- sv/clex_pkg.sv -----
// ----------------------------------------------------------------------------
// clex_pkg: shared types, constants and character helpers for the C lexer
// Holds the scan state layout, the token word layout, the keyword tables and
// the character class functions used by the lexer step and the top level.
// ----------------------------------------------------------------------------
package clex_pkg;

  localparam int MAX_TOKEN_LENGTH = 127;
  localparam int POSITION_WIDTH   = 16;
  localparam int LEN_W            = $clog2(MAX_TOKEN_LENGTH + 1);
  localparam int NUM_KW           = 5;

  localparam int BYTE_W      = 8;
  localparam int CAT_W       = 3;
  localparam int TOK_START_W = 16;
  localparam int TOK_LEN_W   = 7;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_IDENT   = 2'd1,
    MODE_NUMBER  = 2'd2,
    MODE_PENDING = 2'd3
  } mode_e;

  typedef enum logic [CAT_W-1:0] {
    CAT_KEYWORD   = 3'd0,
    CAT_IDENT     = 3'd1,
    CAT_OPERATOR  = 3'd2,
    CAT_LITERAL   = 3'd3,
    CAT_DELIMITER = 3'd4
  } cat_e;

  typedef struct packed {
    mode_e                     mode;
    logic [BYTE_W-1:0]         pend;
    logic [POSITION_WIDTH-1:0] start;
    logic [LEN_W-1:0]          len;
    logic [2*BYTE_W-1:0]       first_two;
    logic [NUM_KW-1:0]         cand;
    logic [POSITION_WIDTH-1:0] pos;
  } lex_state_t;

  typedef struct packed {
    cat_e                   cat;
    logic [TOK_START_W-1:0] start;
    logic [TOK_LEN_W-1:0]   len;
    logic [BYTE_W-1:0]      c0;
    logic [BYTE_W-1:0]      c1;
    logic                   last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } step_res_t;

  // Keywords: int, float, char, return, for. Rows are padded to eight bytes.
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd5, 3'd4, 3'd6, 3'd3};
  localparam logic [BYTE_W-1:0] KW_TEXT [NUM_KW][8] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "l", "o", "a",   "t",   8'h00, 8'h00, 8'h00},
    '{"c", "h", "a", "r",   8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u",   "r",   "n",   8'h00, 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  function automatic logic is_alpha(input logic [BYTE_W-1:0] c);
    return (c inside {["a":"z"], ["A":"Z"]});
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] c);
    return (c inside {["0":"9"]});
  endfunction

  function automatic logic is_space(input logic [BYTE_W-1:0] c);
    return (c inside {" ", [8'd9:8'd13]});
  endfunction

  function automatic logic is_delim(input logic [BYTE_W-1:0] c);
    return (c inside {"(", ")", ";", "{", "}", ","});
  endfunction

  // Keywords whose first byte is c.
  function automatic logic [NUM_KW-1:0] kw_first_mask(input logic [BYTE_W-1:0] c);
    logic [NUM_KW-1:0] m;
    for (int k = 0; k < NUM_KW; k++) begin
      m[k] = (KW_TEXT[k][0] == c);
    end
    return m;
  endfunction

  // Keywords that cannot hold byte c at position idx.
  function automatic logic [NUM_KW-1:0] kw_miss_mask(input logic [LEN_W-1:0] idx,
                                                     input logic [BYTE_W-1:0] c);
    logic [NUM_KW-1:0] m;
    for (int k = 0; k < NUM_KW; k++) begin
      m[k] = (idx >= LEN_W'(KW_LEN[k])) || (KW_TEXT[k][idx[2:0]] != c);
    end
    return m;
  endfunction

  function automatic logic kw_hit(input logic [NUM_KW-1:0] cand,
                                  input logic [LEN_W-1:0] len);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (cand[k] && (LEN_W'(KW_LEN[k]) == len)) hit = 1'b1;
    end
    return hit;
  endfunction

  // Token word for the identifier or literal that is open in st.
  function automatic token_t finish_tok(input lex_state_t st);
    token_t t;
    if (st.mode == MODE_IDENT) begin
      t.cat = kw_hit(st.cand, st.len) ? CAT_KEYWORD : CAT_IDENT;
    end else begin
      t.cat = CAT_LITERAL;
    end
    t.start = TOK_START_W'(st.start);
    t.len   = TOK_LEN_W'(st.len);
    t.c0    = st.first_two[BYTE_W-1:0];
    t.c1    = st.first_two[2*BYTE_W-1:BYTE_W];
    t.last  = 1'b0;
    return t;
  endfunction

  function automatic token_t op_tok(input cat_e cat,
                                    input logic [POSITION_WIDTH-1:0] start,
                                    input logic [TOK_LEN_W-1:0] len,
                                    input logic [BYTE_W-1:0] c0,
                                    input logic [BYTE_W-1:0] c1);
    token_t t;
    t.cat   = cat;
    t.start = TOK_START_W'(start);
    t.len   = len;
    t.c0    = c0;
    t.c1    = c1;
    t.last  = 1'b0;
    return t;
  endfunction

endpackage

// ----- sv/clex_step.sv -----
// ----------------------------------------------------------------------------
// clex_step: combinational scan step of the C lexer
// From the scan state and one text byte, works out the next scan state and up
// to two finished token words.
// ----------------------------------------------------------------------------
module clex_step (
  input  clex_pkg::lex_state_t              st_i,
  input  logic [clex_pkg::BYTE_W-1:0]       byte_i,
  input  logic                              last_i,
  output clex_pkg::lex_state_t              st_o,
  output clex_pkg::step_res_t               res_o
);

  clex_pkg::lex_state_t s;
  clex_pkg::token_t     tok_a;
  clex_pkg::token_t     tok_b;
  logic                 a_v;
  logic                 b_v;
  logic                 done;
  logic [clex_pkg::BYTE_W-1:0] c;
  logic [clex_pkg::BYTE_W-1:0] p;

  always_comb begin
    c     = byte_i;
    s     = st_i;
    p     = st_i.pend;
    tok_a = '0;
    tok_b = '0;
    a_v   = 1'b0;
    b_v   = 1'b0;
    done  = 1'b0;

    // First the byte is offered to whatever is open.
    case (st_i.mode)
      clex_pkg::MODE_PENDING: begin
        if ((c == "=" && (p == "<" || p == ">")) || (c == p && (p == "+" || p == "-"))) begin
          tok_a = clex_pkg::op_tok(clex_pkg::CAT_OPERATOR, st_i.start,
                                   clex_pkg::TOK_LEN_W'(2), p, c);
          a_v   = 1'b1;
          done  = 1'b1;
        end else if (p == "+" || p == "-") begin
          tok_a = clex_pkg::op_tok(clex_pkg::CAT_OPERATOR, st_i.start,
                                   clex_pkg::TOK_LEN_W'(1), p, '0);
          a_v   = 1'b1;
        end
        s.mode = clex_pkg::MODE_IDLE;
      end
      clex_pkg::MODE_IDENT, clex_pkg::MODE_NUMBER: begin
        if ((st_i.mode == clex_pkg::MODE_IDENT &&
             (clex_pkg::is_alpha(c) || clex_pkg::is_digit(c) || c == "_")) ||
            (st_i.mode == clex_pkg::MODE_NUMBER && (clex_pkg::is_digit(c) || c == "."))) begin
          if (st_i.mode == clex_pkg::MODE_IDENT) begin
            s.cand = st_i.cand & ~clex_pkg::kw_miss_mask(st_i.len, c);
          end
          if (st_i.len == clex_pkg::LEN_W'(1)) begin
            s.first_two[2*clex_pkg::BYTE_W-1:clex_pkg::BYTE_W] = c;
          end
          if (st_i.len < clex_pkg::LEN_W'(clex_pkg::MAX_TOKEN_LENGTH)) begin
            s.len = st_i.len + clex_pkg::LEN_W'(1);
          end
          done = 1'b1;
        end else begin
          tok_a  = clex_pkg::finish_tok(st_i);
          a_v    = 1'b1;
          s.mode = clex_pkg::MODE_IDLE;
        end
      end
      default: begin
      end
    endcase

    // Then, if not absorbed, the byte may begin something new.
    if (!done && !clex_pkg::is_space(c)) begin
      if (c == "<" || c == ">" || c == "+" || c == "-") begin
        s.mode  = clex_pkg::MODE_PENDING;
        s.pend  = c;
        s.start = st_i.pos;
      end else if (c == "*" || c == "/" || c == "=") begin
        tok_b = clex_pkg::op_tok(clex_pkg::CAT_OPERATOR, st_i.pos,
                                 clex_pkg::TOK_LEN_W'(1), c, '0);
        b_v   = 1'b1;
      end else if (clex_pkg::is_delim(c)) begin
        tok_b = clex_pkg::op_tok(clex_pkg::CAT_DELIMITER, st_i.pos,
                                 clex_pkg::TOK_LEN_W'(1), c, '0);
        b_v   = 1'b1;
      end else if (clex_pkg::is_digit(c) || clex_pkg::is_alpha(c) || c == "_") begin
        s.mode      = clex_pkg::is_digit(c) ? clex_pkg::MODE_NUMBER : clex_pkg::MODE_IDENT;
        s.start     = st_i.pos;
        s.len       = clex_pkg::LEN_W'(1);
        s.first_two = {{clex_pkg::BYTE_W{1'b0}}, c};
        s.cand      = clex_pkg::is_digit(c) ? '0 : clex_pkg::kw_first_mask(c);
      end
    end

    // End of text flushes what is still open. A single-byte operator or
    // delimiter above always leaves the mode idle, so the two never clash.
    if (last_i) begin
      if (s.mode == clex_pkg::MODE_IDENT || s.mode == clex_pkg::MODE_NUMBER) begin
        tok_b = clex_pkg::finish_tok(s);
        b_v   = 1'b1;
      end else if (s.mode == clex_pkg::MODE_PENDING && (s.pend == "+" || s.pend == "-")) begin
        tok_b = clex_pkg::op_tok(clex_pkg::CAT_OPERATOR, s.start,
                                 clex_pkg::TOK_LEN_W'(1), s.pend, '0);
        b_v   = 1'b1;
      end
      s.mode = clex_pkg::MODE_IDLE;
      s.cand = '1;
      s.pos  = '0;
    end else begin
      s.pos = st_i.pos + clex_pkg::POSITION_WIDTH'(1);
    end

    st_o = s;

    // Pack the emitted words, first one first, and mark the final one.
    res_o = '0;
    if (a_v && b_v) begin
      res_o.count     = 2'd2;
      res_o.tok0      = tok_a;
      res_o.tok1      = tok_b;
      res_o.tok1.last = 1'b1;
    end else if (a_v || b_v) begin
      res_o.count     = 2'd1;
      res_o.tok0      = a_v ? tok_a : tok_b;
      res_o.tok0.last = 1'b1;
    end
  end

endmodule

// ----- sv/clex_res_fifo.sv -----
// ----------------------------------------------------------------------------
// clex_res_fifo: two-entry token word queue
// Takes zero, one or two token words per cycle and hands them out one a cycle
// on a valid/ready channel, while the receiver holds ready high.
// ----------------------------------------------------------------------------
module clex_res_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           push_count_i,
  input  clex_pkg::token_t     push0_i,
  input  clex_pkg::token_t     push1_i,
  output logic [1:0]           free_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output clex_pkg::token_t     out_tok_o
);

  clex_pkg::token_t slot_q [2];
  clex_pkg::token_t slot_d [2];
  logic [1:0]       cnt_q;
  logic [1:0]       cnt_d;
  logic [1:0]       cnt_rem;
  logic             pop;

  assign pop         = (cnt_q != 2'd0) && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_tok_o   = slot_q[0];
  assign free_o      = 2'd2 - cnt_q + {1'b0, pop};

  always_comb begin
    cnt_rem   = cnt_q - {1'b0, pop};
    slot_d[0] = pop ? slot_q[1] : slot_q[0];
    slot_d[1] = slot_q[1];
    case (push_count_i)
      2'd1: begin
        slot_d[cnt_rem[0]] = push0_i;
      end
      2'd2: begin
        slot_d[0] = push0_i;
        slot_d[1] = push1_i;
      end
      default: begin
      end
    endcase
    cnt_d = cnt_rem + push_count_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

endmodule

// ----- sv/c_subset_lexer_core.sv -----
// ----------------------------------------------------------------------------
// c_subset_lexer_core: streaming lexer for a small subset of C
// Turns a stream of source bytes into token words carrying category, start
// position, length and the first two characters.
// ----------------------------------------------------------------------------
// Usage. Source text enters one byte per word on the input channel
// (text_byte_i, with end_of_text_i high on the final byte of a text). Token
// words leave on the output channel, one per cycle while ready is high;
// last_of_run_o marks the final token word caused by a given input byte. A
// byte may cause no token, one token or two tokens.
//
// Flow. An accepted byte is held in an input register; a single pass of
// combinational scan logic then updates the scan state and writes its token
// words into a two-entry output queue, from whose register the first token
// word is offered. One byte is taken every cycle while each byte yields at
// most one token and the receiver keeps up; bytes yielding two tokens slow
// the input, as the output channel moves one token word per cycle.
//
// Stalls. When the receiver holds ready low, the queue fills and the byte in
// the input register waits until there is room for all of its tokens; only
// then is in_ready_o raised again. Nothing is lost or repeated.
//
// Reset. rst_ni clears the queue, empties the input register and returns the
// scanner to idle with the byte position at zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
module c_subset_lexer_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [clex_pkg::BYTE_W-1:0]         text_byte_i,
  input  logic                                end_of_text_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [clex_pkg::CAT_W-1:0]          token_category_o,
  output logic [clex_pkg::TOK_START_W-1:0]    token_start_o,
  output logic [clex_pkg::TOK_LEN_W-1:0]      token_length_o,
  output logic [clex_pkg::BYTE_W-1:0]         first_char_o,
  output logic [clex_pkg::BYTE_W-1:0]         second_char_o,
  output logic                                last_of_run_o
);

  // Input register.
  logic                          in_valid_q;
  logic [clex_pkg::BYTE_W-1:0]   byte_q;
  logic                          last_q;

  // Scan state.
  clex_pkg::lex_state_t st_q;
  clex_pkg::lex_state_t st_d;

  clex_pkg::step_res_t  step_res;
  clex_pkg::token_t     out_tok;
  logic [1:0]           free;
  logic                 consume;
  logic [1:0]           push_count;

  // The held byte is consumed once the queue can take every token it causes.
  assign consume    = in_valid_q && (step_res.count <= free);
  assign push_count = consume ? step_res.count : 2'd0;
  assign in_ready_o = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= text_byte_i;
      last_q <= end_of_text_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode      <= clex_pkg::MODE_IDLE;
      st_q.pend      <= '0;
      st_q.start     <= '0;
      st_q.len       <= '0;
      st_q.first_two <= '0;
      st_q.cand      <= '1;
      st_q.pos       <= '0;
    end else if (consume) begin
      st_q <= st_d;
    end
  end

  clex_step u_step (
    .st_i   (st_q),
    .byte_i (byte_q),
    .last_i (last_q),
    .st_o   (st_d),
    .res_o  (step_res)
  );

  clex_res_fifo u_res_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_count_i (push_count),
    .push0_i      (step_res.tok0),
    .push1_i      (step_res.tok1),
    .free_o       (free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_tok_o    (out_tok)
  );

  assign token_category_o = out_tok.cat;
  assign token_start_o    = out_tok.start;
  assign token_length_o   = out_tok.len;
  assign first_char_o     = out_tok.c0;
  assign second_char_o    = out_tok.c1;
  assign last_of_run_o    = out_tok.last;

endmodule
